// ----- hdl/rise_pkg.sv -----
`timescale 1ns / 1ps
package rise_pkg;

  // Data store depth in words (power of two) and program counter width
  localparam int unsigned DMEM_DEPTH = 1024;
  localparam int unsigned DMEM_AW    = $clog2(DMEM_DEPTH);
  localparam int unsigned PC_WIDTH   = 16;

  localparam int unsigned NUM_REGS   = 32;
  localparam int unsigned REG_AW     = $clog2(NUM_REGS);
  localparam int unsigned XLEN       = 32;

  // Primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_SLTI  = 6'h0A;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2B;

  // R-type function codes
  localparam logic [5:0] FN_ADD = 6'h20;
  localparam logic [5:0] FN_SUB = 6'h22;
  localparam logic [5:0] FN_AND = 6'h24;
  localparam logic [5:0] FN_OR  = 6'h25;
  localparam logic [5:0] FN_SLT = 6'h2A;

  // Outcome of one executed instruction
  typedef struct packed {
    logic [PC_WIDTH-1:0] npc;
    logic                taken;
    logic                wr;
    logic [REG_AW-1:0]   widx;
    logic [XLEN-1:0]     wval;
    logic                load;
    logic                st;
    logic [DMEM_AW-1:0]  midx;
    logic [XLEN-1:0]     sval;
    logic                ill;
  } exec_res_t;

endpackage

// ----- hdl/rise_regfile.sv -----
`timescale 1ns / 1ps
module rise_regfile (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [rise_pkg::REG_AW-1:0] raddr_a_i,
  input  logic [rise_pkg::REG_AW-1:0] raddr_b_i,
  output logic [rise_pkg::XLEN-1:0]   rdata_a_o,
  output logic [rise_pkg::XLEN-1:0]   rdata_b_o,
  input  logic                       wr_en_i,
  input  logic [rise_pkg::REG_AW-1:0] waddr_i,
  input  logic [rise_pkg::XLEN-1:0]   wdata_i
);
  import rise_pkg::*;

  logic [XLEN-1:0]     mem [NUM_REGS];
  logic [NUM_REGS-1:0] written_q;
  logic [XLEN-1:0]     rdata_a_q, rdata_b_q;
  logic                rvld_a_q, rvld_b_q;

  // Track entries written since reset; unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_en_i) begin
      written_q[waddr_i] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
      rvld_a_q  <= written_q[raddr_a_i];
      rvld_b_q  <= written_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rvld_a_q ? rdata_a_q : '0;
  assign rdata_b_o = rvld_b_q ? rdata_b_q : '0;

endmodule

// ----- hdl/rise_dmem.sv -----
`timescale 1ns / 1ps
module rise_dmem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  output logic                        busy_o,
  input  logic                        en_i,
  input  logic                        we_i,
  input  logic [rise_pkg::DMEM_AW-1:0] addr_i,
  input  logic [rise_pkg::XLEN-1:0]    wdata_i,
  output logic [rise_pkg::XLEN-1:0]    rdata_o
);
  import rise_pkg::*;

  localparam logic [DMEM_AW-1:0] LastAddr = DMEM_AW'(DMEM_DEPTH - 1);

  logic [XLEN-1:0]    mem [DMEM_DEPTH];
  logic [XLEN-1:0]    rdata_q;
  logic               busy_q, busy_d;
  logic [DMEM_AW-1:0] clr_addr_q, clr_addr_d;

  // Sweep every word to all ones after reset
  always_comb begin
    busy_d     = busy_q;
    clr_addr_d = clr_addr_q;
    if (busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == LastAddr) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      busy_q     <= busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Single port: sweep write, store write or load read
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_addr_q] <= '1;
    end else if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign busy_o  = busy_q;
  assign rdata_o = rdata_q;

endmodule

// ----- hdl/rise_exec.sv -----
`timescale 1ns / 1ps
module rise_exec (
  input  logic [31:0]                 instr_i,
  input  logic [rise_pkg::PC_WIDTH-1:0] pc_i,
  input  logic [rise_pkg::XLEN-1:0]     op_a_i,
  input  logic [rise_pkg::XLEN-1:0]     op_b_i,
  output rise_pkg::exec_res_t          res_o
);
  import rise_pkg::*;

  logic [5:0]          opcode, funct;
  logic [REG_AW-1:0]   rt, rd;
  logic [XLEN-1:0]     imm_s, imm_z, addr_sum, seq_w;
  logic [PC_WIDTH-1:0] seq;
  exec_res_t           r;

  assign opcode   = instr_i[31:26];
  assign funct    = instr_i[5:0];
  assign rt       = instr_i[20:16];
  assign rd       = instr_i[15:11];
  assign imm_s    = {{16{instr_i[15]}}, instr_i[15:0]};
  assign imm_z    = {16'h0000, instr_i[15:0]};
  assign seq      = pc_i + PC_WIDTH'(1);
  assign seq_w    = XLEN'(seq);
  assign addr_sum = op_a_i + imm_s;

  // Decode and execute
  always_comb begin
    r       = '0;
    r.npc   = seq;
    unique case (opcode)
      OP_RTYPE: begin
        r.wr   = 1'b1;
        r.widx = rd;
        unique case (funct)
          FN_ADD: r.wval = op_a_i + op_b_i;
          FN_SUB: r.wval = op_a_i - op_b_i;
          FN_AND: r.wval = op_a_i & op_b_i;
          FN_OR:  r.wval = op_a_i | op_b_i;
          FN_SLT: r.wval = XLEN'($signed(op_a_i) < $signed(op_b_i));
          default: begin
            r.wr  = 1'b0;
            r.ill = 1'b1;
          end
        endcase
      end
      OP_ADDI: begin
        r.wr = 1'b1; r.widx = rt; r.wval = addr_sum;
      end
      OP_SLTI: begin
        r.wr = 1'b1; r.widx = rt; r.wval = XLEN'($signed(op_a_i) < $signed(imm_s));
      end
      OP_ANDI: begin
        r.wr = 1'b1; r.widx = rt; r.wval = op_a_i & imm_z;
      end
      OP_ORI: begin
        r.wr = 1'b1; r.widx = rt; r.wval = op_a_i | imm_z;
      end
      OP_LW: begin
        r.wr = 1'b1; r.widx = rt; r.load = 1'b1;
        r.midx = addr_sum[DMEM_AW-1:0];
      end
      OP_SW: begin
        r.st = 1'b1; r.sval = op_b_i;
        r.midx = addr_sum[DMEM_AW-1:0];
      end
      OP_BEQ, OP_BNE: begin
        if ((opcode == OP_BEQ) == (op_a_i == op_b_i)) begin
          r.taken = 1'b1;
          r.npc   = PC_WIDTH'(seq_w + imm_s);
        end
      end
      OP_J: begin
        r.taken = 1'b1;
        r.npc   = PC_WIDTH'({seq_w[31:26], instr_i[25:0]});
      end
      default: r.ill = 1'b1;
    endcase
    // Drop writes to r0
    if (!r.wr || r.widx == '0) begin
      r.wr   = 1'b0;
      r.widx = '0;
      r.wval = '0;
      r.load = 1'b0;
    end
    res_o = r;
  end

endmodule

// ----- hdl/risc_integer_subset_executor.sv -----
`timescale 1ns / 1ps
// m_axis_tvalid_o rises once an accepted instruction has passed the s2 and s3 registers.
// Throughput: one instruction per cycle unless the output stalls or the data store sweeps;
// the register file takes two reads and one write and the data store one access per cycle,
// and results are forwarded, so no interlock stalls.
// Reset: PC and register file clear at once; the data store is then filled with all ones
// in a sweep over all DMEM_DEPTH (1024) words during which s_axis_tready_o is low.
module risc_integer_subset_executor (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [31:0]   s_axis_tdata_i,  // [31:0] instr
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [15:0] next_pc, [16] branch_taken, [17] wb_valid, [22:18] wb_index,
  // [54:23] wb_value, [55] store_valid, [65:56] mem_index, [97:66] store_value,
  // [98] illegal, [103:99] zero
  output logic [103:0]  m_axis_tdata_o
);
  import rise_pkg::*;

  logic                advance, accept, dmem_busy;
  logic                s2_vld_q, s3_vld_q, w_vld_q;
  logic [31:0]         s2_instr_q;
  logic [PC_WIDTH-1:0] pc_q;
  exec_res_t           ex_res, s3_res_q;
  logic [REG_AW-1:0]   w_idx_q, s2_rs, s2_rt;
  logic [XLEN-1:0]     w_val_q, rf_a, rf_b, op_a, op_b, s3_wval, dmem_rdata;

  // Whole pipe moves when the output stage is empty or being drained
  assign advance         = !s3_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = advance && !dmem_busy;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  rise_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .raddr_a_i (s_axis_tdata_i[25:21]),
    .raddr_b_i (s_axis_tdata_i[20:16]),
    .rdata_a_o (rf_a),
    .rdata_b_o (rf_b),
    .wr_en_i   (advance && s3_vld_q && s3_res_q.wr),
    .waddr_i   (s3_res_q.widx),
    .wdata_i   (s3_wval)
  );

  // Forward from the output stage, then from the last retired write
  assign s2_rs = s2_instr_q[25:21];
  assign s2_rt = s2_instr_q[20:16];

  always_comb begin
    op_a = rf_a;
    op_b = rf_b;
    if (s3_vld_q && s3_res_q.wr && s3_res_q.widx == s2_rs) begin
      op_a = s3_wval;
    end else if (w_vld_q && w_idx_q == s2_rs) begin
      op_a = w_val_q;
    end
    if (s3_vld_q && s3_res_q.wr && s3_res_q.widx == s2_rt) begin
      op_b = s3_wval;
    end else if (w_vld_q && w_idx_q == s2_rt) begin
      op_b = w_val_q;
    end
  end

  rise_exec u_exec (
    .instr_i (s2_instr_q),
    .pc_i    (pc_q),
    .op_a_i  (op_a),
    .op_b_i  (op_b),
    .res_o   (ex_res)
  );

  rise_dmem u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .busy_o  (dmem_busy),
    .en_i    (advance && s2_vld_q && (ex_res.load || ex_res.st)),
    .we_i    (ex_res.st),
    .addr_i  (ex_res.midx),
    .wdata_i (ex_res.sval),
    .rdata_o (dmem_rdata)
  );

  assign s3_wval = s3_res_q.load ? dmem_rdata : s3_res_q.wval;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      w_vld_q  <= 1'b0;
      pc_q     <= '0;
    end else if (advance) begin
      s2_vld_q <= accept;
      s3_vld_q <= s2_vld_q;
      w_vld_q  <= s3_vld_q && s3_res_q.wr;
      if (s2_vld_q) begin
        pc_q <= ex_res.npc;
      end
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_instr_q <= s_axis_tdata_i;
    end
    if (advance) begin
      s3_res_q <= ex_res;
      w_idx_q  <= s3_res_q.widx;
      w_val_q  <= s3_wval;
    end
  end

  // Pack the result
  assign m_axis_tvalid_o = s3_vld_q;
  assign m_axis_tdata_o  = {5'b00000,
                            s3_res_q.ill,
                            s3_res_q.sval,
                            10'(s3_res_q.midx),
                            s3_res_q.st,
                            s3_wval,
                            s3_res_q.widx,
                            s3_res_q.wr,
                            s3_res_q.taken,
                            16'(s3_res_q.npc)};

endmodule

// ----- hdl/rise_checker.sv -----
`timescale 1ns / 1ps
module rise_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [31:0]  s_axis_tdata_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [103:0] m_axis_tdata_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result withdrawn while stalled");

  // Each input transfer shows up as a result, after the s2 and s3 registers, when the output is free
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && m_axis_tready_i ##1 m_axis_tready_i
    |=> m_axis_tvalid_o)
    else $error("result missing after input transfer");

  // No write-back to r0, and empty fields when nothing is written
  a_wb_r0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[17] ? (m_axis_tdata_o[22:18] != 5'd0)
                         : (m_axis_tdata_o[22:18] == 5'd0 && m_axis_tdata_o[54:23] == '0)))
    else $error("bad write-back fields");

  // An illegal instruction has no side effect
  a_illegal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[98] |->
      !m_axis_tdata_o[16] && !m_axis_tdata_o[17] && !m_axis_tdata_o[55])
    else $error("illegal instruction had an effect");

  // A store never writes a register
  a_store_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[55] |-> !m_axis_tdata_o[17])
    else $error("store reported a write-back");

endmodule

bind risc_integer_subset_executor rise_checker u_rise_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
